// ===== hdl/btkhq_pkg.sv =====
// Package for the bounded top-k heap queue.
// Holds command codes, register indexes, sequencer states and default sizes.
// No dependencies.
package btkhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [0:0] REG_MAX_ENTRIES    = 1'b0;
  localparam logic [0:0] REG_ORDER_REVERSED = 1'b1;

  localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIFT_UP,
    ST_SIFT_DOWN,
    ST_POP_LAST,
    ST_SCAN,
    ST_RM_LAST
  } state_t;

endpackage

// ===== hdl/bounded_top_k_heap_queue.sv =====
// Top level of the bounded top-k heap queue: sequencer around one entry memory.
// Depends on btkhq_pkg.
//
// channel  ports                        handshake
// input    in_cmd, in_key, in_entry_id  start & !busy
// result   out_*                        out_strobe, one cycle, no backpressure
// config   cfg_index, cfg_data          cfg_valid & cfg_ready (always ready)
//
// Clear, ignored codes and rejected commands answer one cycle after the beat.
// Adds and inserts that change the heap sift the entry, one memory read per heap level;
// pop first fetches the last entry. Remove scans one entry per cycle, then
// fetches the last entry and sifts. No clearing pass after reset (synchronous rst_n).
module bounded_top_k_heap_queue
  import btkhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_entry_id,
  output logic        out_strobe,
  output logic        out_valid,
  output logic [31:0] out_key,
  output logic [31:0] out_id,
  output logic        out_found,
  output logic        out_error_flag,
  output logic        out_top_valid,
  output logic [31:0] out_top_key,
  output logic [31:0] out_top_id,
  output logic [10:0] out_entry_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW  = $clog2(CAPACITY + 1);
  localparam int CMW = (PW > 11) ? PW : 11;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         id;
  } ent_t;

  ent_t mem [CAPACITY];

  state_t        state_r, state_nxt;
  logic [PW-1:0] count_r, count_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [PW:0]   scan_r, scan_nxt;
  logic          sda_r, sda_nxt;
  ent_t          e_r, e_nxt;
  ent_t          top_r, top_nxt;
  ent_t          rda_r, rdb_r;
  logic [10:0]   max_entries_r;
  logic          reversed_r;

  logic                res_ov_r, res_ov_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [31:0]         res_id_r, res_id_nxt;
  logic                res_fnd_r, res_fnd_nxt;
  logic                res_err_r, res_err_nxt;

  logic          done;
  logic [PW:0]   rpa, rpb;
  logic          wr_en;
  logic [PW-1:0] wr_pos;
  ent_t          wr_data;

  logic                out_strobe_r, out_valid_r, out_found_r, out_err_r, out_top_valid_r;
  logic [31:0]         out_key_r, out_id_r, out_top_key_r, out_top_id_r;
  logic [10:0]         out_count_r;

  logic [CMW-1:0] cap;
  logic [CMW-1:0] count_w;
  ent_t           in_ent;
  logic [PW:0]    c0, c1;
  ent_t           best;
  logic [PW:0]    best_pos;

  function automatic logic ranks_before(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b, input logic rev);
    ranks_before = rev ? (a > b) : (a < b);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign count_w   = CMW'(count_r);
  assign cap       = (CMW'(max_entries_r) < CMW'(CAPACITY)) ? CMW'(max_entries_r)
                                                            : CMW'(CAPACITY);
  assign in_ent.key = KEY_BITS'(in_key);
  assign in_ent.id  = in_entry_id;

  assign c0 = {cur_r, 1'b0};
  assign c1 = {cur_r, 1'b1};

  always_comb begin
    if ((c1 <= (PW+1)'(count_r)) && ranks_before(rdb_r.key, rda_r.key, reversed_r)) begin
      best     = rdb_r;
      best_pos = c1;
    end else begin
      best     = rda_r;
      best_pos = c0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    scan_nxt    = scan_r;
    sda_nxt     = sda_r;
    e_nxt       = e_r;
    res_ov_nxt  = res_ov_r;
    res_key_nxt = res_key_r;
    res_id_nxt  = res_id_r;
    res_fnd_nxt = res_fnd_r;
    res_err_nxt = res_err_r;
    done        = 1'b0;
    rpa         = '0;
    rpb         = '0;
    wr_en       = 1'b0;
    wr_pos      = cur_r;
    wr_data     = e_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          res_ov_nxt  = 1'b0;
          res_key_nxt = '0;
          res_id_nxt  = '0;
          res_fnd_nxt = 1'b0;
          res_err_nxt = 1'b0;
          e_nxt       = in_ent;
          case (in_cmd)
            CMD_ADD, CMD_INSERT: begin
              if (count_w < cap) begin
                count_nxt = count_r + 1'b1;
                cur_nxt   = count_r + 1'b1;
                start_nxt = count_r + 1'b1;
                sda_nxt   = 1'b0;
                rpa       = (PW+1)'((count_r + 1'b1) >> 1);
                state_nxt = ST_SIFT_UP;
              end else if (in_cmd == CMD_ADD) begin
                res_err_nxt = 1'b1;
                done        = 1'b1;
              end else if ((count_r != '0) && ranks_before(top_r.key, in_ent.key,
                                                            reversed_r)) begin
                res_ov_nxt  = 1'b1;
                res_key_nxt = top_r.key;
                res_id_nxt  = top_r.id;
                cur_nxt     = PW'(1);
                rpa         = (PW+1)'(2);
                rpb         = (PW+1)'(3);
                state_nxt   = ST_SIFT_DOWN;
              end else begin
                res_ov_nxt  = 1'b1;
                res_key_nxt = in_ent.key;
                res_id_nxt  = in_ent.id;
                done        = 1'b1;
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_err_nxt = 1'b1;
                done        = 1'b1;
              end else begin
                res_ov_nxt  = 1'b1;
                res_key_nxt = top_r.key;
                res_id_nxt  = top_r.id;
                rpa         = (PW+1)'(count_r);
                state_nxt   = ST_POP_LAST;
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                done = 1'b1;
              end else begin
                rpa       = (PW+1)'(1);
                cur_nxt   = PW'(1);
                scan_nxt  = (PW+1)'(2);
                state_nxt = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              done      = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_SIFT_UP: begin
        wr_en = 1'b1;
        if ((cur_r > PW'(1)) && ranks_before(e_r.key, rda_r.key, reversed_r)) begin
          wr_data = rda_r;
          cur_nxt = cur_r >> 1;
          rpa     = (PW+1)'(cur_r >> 2);
        end else if (sda_r && (cur_r == start_r)) begin
          rpa       = c0;
          rpb       = c1;
          state_nxt = ST_SIFT_DOWN;
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SIFT_DOWN: begin
        wr_en = 1'b1;
        if ((c0 <= (PW+1)'(count_r)) && ranks_before(best.key, e_r.key, reversed_r)) begin
          wr_data = best;
          cur_nxt = PW'(best_pos);
          rpa     = {PW'(best_pos), 1'b0};
          rpb     = {PW'(best_pos), 1'b1};
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP_LAST: begin
        count_nxt = count_r - 1'b1;
        if (count_r == PW'(1)) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          e_nxt     = rda_r;
          cur_nxt   = PW'(1);
          rpa       = (PW+1)'(2);
          rpb       = (PW+1)'(3);
          state_nxt = ST_SIFT_DOWN;
        end
      end
      ST_SCAN: begin
        if (rda_r.id == e_r.id) begin
          res_fnd_nxt = 1'b1;
          rpa         = (PW+1)'(count_r);
          state_nxt   = ST_RM_LAST;
        end else if (scan_r <= (PW+1)'(count_r)) begin
          rpa      = scan_r;
          cur_nxt  = PW'(scan_r);
          scan_nxt = scan_r + 1'b1;
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RM_LAST: begin
        count_nxt = count_r - 1'b1;
        if (cur_r <= count_r - 1'b1) begin
          e_nxt     = rda_r;
          start_nxt = cur_r;
          sda_nxt   = 1'b1;
          rpa       = (PW+1)'(cur_r >> 1);
          state_nxt = ST_SIFT_UP;
        end else begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    top_nxt = top_r;
    if (wr_en && (wr_pos == PW'(1))) begin
      top_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_pos - 1'b1)] <= wr_data;
    end
    rda_r <= mem[AW'(rpa - 1'b1)];
    rdb_r <= mem[AW'(rpb - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      reversed_r    <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= done;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_ENTRIES:    max_entries_r <= cfg_data;
          REG_ORDER_REVERSED: reversed_r    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    start_r   <= start_nxt;
    scan_r    <= scan_nxt;
    sda_r     <= sda_nxt;
    e_r       <= e_nxt;
    top_r     <= top_nxt;
    res_ov_r  <= res_ov_nxt;
    res_key_r <= res_key_nxt;
    res_id_r  <= res_id_nxt;
    res_fnd_r <= res_fnd_nxt;
    res_err_r <= res_err_nxt;
    if (done) begin
      out_valid_r     <= res_ov_nxt;
      out_key_r       <= 32'(res_key_nxt);
      out_id_r        <= res_id_nxt;
      out_found_r     <= res_fnd_nxt;
      out_err_r       <= res_err_nxt;
      out_top_valid_r <= (count_nxt != '0);
      out_top_key_r   <= (count_nxt != '0) ? 32'(top_nxt.key) : 32'd0;
      out_top_id_r    <= (count_nxt != '0) ? top_nxt.id : 32'd0;
      out_count_r     <= 11'(count_nxt);
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_valid       = out_valid_r;
  assign out_key         = out_key_r;
  assign out_id          = out_id_r;
  assign out_found       = out_found_r;
  assign out_error_flag  = out_err_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_top_key     = out_top_key_r;
  assign out_top_id      = out_top_id_r;
  assign out_entry_count = out_count_r;

endmodule

// ===== hdl/btkhq_checker.sv =====
// Port-level checks for the bounded top-k heap queue, bound to the top level.
// Depends on btkhq_pkg through the top level only.
module btkhq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_valid,
  input logic        out_found,
  input logic        out_error_flag,
  input logic        out_top_valid,
  input logic [31:0] out_top_key,
  input logic [10:0] out_entry_count
);

  a_top_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_top_valid == (out_entry_count != 11'd0)))
    else $error("top valid disagrees with count");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_top_valid) |-> (out_top_key == 32'd0))
    else $error("empty heap shows a top key");

  a_err_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_error_flag) |-> (!out_valid && !out_found))
    else $error("error beat carries an entry");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("busy or strobe after reset");

endmodule

bind bounded_top_k_heap_queue btkhq_checker u_btkhq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_valid       (out_valid),
  .out_found       (out_found),
  .out_error_flag  (out_error_flag),
  .out_top_valid   (out_top_valid),
  .out_top_key     (out_top_key),
  .out_entry_count (out_entry_count)
);

// ===== verif/tb_bounded_top_k_heap_queue.sv =====
// Self-checking testbench for the bounded top-k heap queue.
// Predicts every result with a behavioral heap model and checks each strobed result.
// Depends on btkhq_pkg and bounded_top_k_heap_queue.
`timescale 1ns / 100ps

module tb_bounded_top_k_heap_queue;
  import btkhq_pkg::*;

  localparam int DEPTH = CAPACITY_DEF;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic        valid;
    logic [31:0] okey;
    logic [31:0] oid;
    logic        found;
    logic        err;
    logic        tvalid;
    logic [31:0] tkey;
    logic [31:0] tid;
    logic [10:0] cnt;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [31:0] in_key;
  logic [31:0] in_entry_id;
  logic        out_strobe;
  logic        out_valid;
  logic [31:0] out_key;
  logic [31:0] out_id;
  logic        out_found;
  logic        out_error_flag;
  logic        out_top_valid;
  logic [31:0] out_top_key;
  logic [31:0] out_top_id;
  logic [10:0] out_entry_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;

  bounded_top_k_heap_queue i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_entry_id(in_entry_id),
    .out_strobe(out_strobe), .out_valid(out_valid), .out_key(out_key), .out_id(out_id),
    .out_found(out_found), .out_error_flag(out_error_flag),
    .out_top_valid(out_top_valid), .out_top_key(out_top_key), .out_top_id(out_top_id),
    .out_entry_count(out_entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // heap model state, 1-based
  logic [31:0] mdl_keys [1:DEPTH];
  logic [31:0] mdl_ids  [1:DEPTH];
  int          mdl_count;
  logic [10:0] mdl_max_entries;
  logic        mdl_reversed;

  heap_result_t pending_results[$];
  int           fail_count;
  longint       cycle_count;
  bit           idle_enable;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit ranks_ahead(logic [31:0] a, logic [31:0] b);
    return mdl_reversed ? (a > b) : (a < b);
  endfunction

  function automatic bit heap_sift_up(int pos);
    logic [31:0] k;
    logic [31:0] d;
    int cur;
    int par;
    k = mdl_keys[pos];
    d = mdl_ids[pos];
    cur = pos;
    par = cur >> 1;
    while (par > 0 && ranks_ahead(k, mdl_keys[par])) begin
      mdl_keys[cur] = mdl_keys[par];
      mdl_ids[cur] = mdl_ids[par];
      cur = par;
      par = par >> 1;
    end
    mdl_keys[cur] = k;
    mdl_ids[cur] = d;
    return cur != pos;
  endfunction

  function automatic int heap_better_child(int cur);
    int c;
    c = cur << 1;
    if (c + 1 <= mdl_count && ranks_ahead(mdl_keys[c + 1], mdl_keys[c])) c = c + 1;
    return c;
  endfunction

  function automatic void heap_sift_down(int pos);
    logic [31:0] k;
    logic [31:0] d;
    int cur;
    int c;
    k = mdl_keys[pos];
    d = mdl_ids[pos];
    cur = pos;
    c = heap_better_child(cur);
    while (c <= mdl_count && ranks_ahead(mdl_keys[c], k)) begin
      mdl_keys[cur] = mdl_keys[c];
      mdl_ids[cur] = mdl_ids[c];
      cur = c;
      c = heap_better_child(cur);
    end
    mdl_keys[cur] = k;
    mdl_ids[cur] = d;
  endfunction

  function automatic void heap_push(logic [31:0] k, logic [31:0] d);
    mdl_count++;
    mdl_keys[mdl_count] = k;
    mdl_ids[mdl_count] = d;
    void'(heap_sift_up(mdl_count));
  endfunction

  function automatic heap_result_t predict_heap_op(logic [2:0] cmd, logic [31:0] k,
                                                   logic [31:0] d);
    heap_result_t r;
    int cap;
    bit hit;
    r = '0;
    hit = 1'b0;
    cap = (mdl_max_entries < DEPTH) ? int'(mdl_max_entries) : DEPTH;
    case (cmd)
      CMD_ADD: begin
        if (mdl_count >= cap) r.err = 1'b1;
        else heap_push(k, d);
      end
      CMD_INSERT: begin
        if (mdl_count < cap) begin
          heap_push(k, d);
        end else if (mdl_count > 0 && ranks_ahead(mdl_keys[1], k)) begin
          r.valid = 1'b1;
          r.okey = mdl_keys[1];
          r.oid = mdl_ids[1];
          mdl_keys[1] = k;
          mdl_ids[1] = d;
          heap_sift_down(1);
        end else begin
          r.valid = 1'b1;
          r.okey = k;
          r.oid = d;
        end
      end
      CMD_POP: begin
        if (mdl_count == 0) begin
          r.err = 1'b1;
        end else begin
          r.valid = 1'b1;
          r.okey = mdl_keys[1];
          r.oid = mdl_ids[1];
          mdl_keys[1] = mdl_keys[mdl_count];
          mdl_ids[1] = mdl_ids[mdl_count];
          mdl_count--;
          if (mdl_count > 0) heap_sift_down(1);
        end
      end
      CMD_REMOVE: begin
        for (int i = 1; i <= mdl_count && !hit; i++) begin
          if (mdl_ids[i] == d) begin
            mdl_keys[i] = mdl_keys[mdl_count];
            mdl_ids[i] = mdl_ids[mdl_count];
            mdl_count--;
            if (i <= mdl_count) begin
              if (!heap_sift_up(i)) heap_sift_down(i);
            end
            hit = 1'b1;
          end
        end
        r.found = hit;
      end
      CMD_CLEAR: mdl_count = 0;
      default: ;
    endcase
    if (mdl_count > 0) begin
      r.tvalid = 1'b1;
      r.tkey = mdl_keys[1];
      r.tid = mdl_ids[1];
    end
    r.cnt = mdl_count[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%08h expected 0x%08h at cycle %0d", what, got, want,
             cycle_count);
    fail_count++;
  endtask

  always @(posedge clk) begin
    heap_result_t w;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_valid !== w.valid)
          report_mismatch("out_valid", 32'(out_valid), 32'(w.valid));
        if (out_key !== w.okey) report_mismatch("out_key", out_key, w.okey);
        if (out_id !== w.oid) report_mismatch("out_id", out_id, w.oid);
        if (out_found !== w.found)
          report_mismatch("found", 32'(out_found), 32'(w.found));
        if (out_error_flag !== w.err)
          report_mismatch("error_flag", 32'(out_error_flag), 32'(w.err));
        if (out_top_valid !== w.tvalid)
          report_mismatch("top_valid", 32'(out_top_valid), 32'(w.tvalid));
        if (out_top_key !== w.tkey) report_mismatch("top_key", out_top_key, w.tkey);
        if (out_top_id !== w.tid) report_mismatch("top_id", out_top_id, w.tid);
        if (out_entry_count !== w.cnt)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(w.cnt));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge with start still high unless an idle gap was taken
  task automatic send_beat(logic [2:0] cmd, logic [31:0] k, logic [31:0] d);
    int gap;
    start = 1'b1;
    in_cmd = cmd;
    in_key = k;
    in_entry_id = d;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_heap_op(cmd, k, d));
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 99) < 26) begin
      start = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [10:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MAX_ENTRIES) mdl_max_entries = value;
    else mdl_reversed = value[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom_range(0, 15);
    if (sel < 50) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 31);
    return $urandom;
  endfunction

  task automatic send_random_beat(int clear_pct);
    int sel;
    logic [2:0] cmd;
    logic [31:0] d;
    sel = $urandom_range(0, 99);
    if (sel < clear_pct) cmd = CMD_CLEAR;
    else if (sel < 32) cmd = CMD_ADD;
    else if (sel < 58) cmd = CMD_INSERT;
    else if (sel < 78) cmd = CMD_POP;
    else if (sel < 97) cmd = CMD_REMOVE;
    else cmd = 3'($urandom_range(5, 7));
    d = pick_id();
    if (cmd == CMD_REMOVE && mdl_count > 0 && $urandom_range(0, 9) < 7)
      d = mdl_ids[$urandom_range(1, mdl_count)];
    send_beat(cmd, pick_key(), d);
  endtask

  task automatic test_directed();
    send_beat(CMD_POP, 32'd0, 32'd0);
    send_beat(CMD_REMOVE, 32'd0, 32'hFFFF_FFFF);
    send_beat(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_ADD, 32'd0, 32'd0);
    send_beat(CMD_ADD, 32'd5, 32'd10);
    send_beat(CMD_ADD, 32'd5, 32'd11);
    send_beat(CMD_ADD, 32'd5, 32'd12);
    send_beat(CMD_INSERT, 32'd3, 32'd13);
    send_beat(CMD_REMOVE, 32'd0, 32'd11);
    send_beat(CMD_REMOVE, 32'd0, 32'd99);
    send_beat(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(3'd6, 32'd1, 32'd1);
    send_beat(3'd7, 32'd2, 32'd2);
    send_beat(CMD_POP, 32'd0, 32'd0);
    send_beat(CMD_CLEAR, 32'd0, 32'd0);
    write_register(REG_MAX_ENTRIES, 11'd0);
    send_beat(CMD_ADD, 32'd7, 32'd1);
    send_beat(CMD_INSERT, 32'd7, 32'd2);
    write_register(REG_MAX_ENTRIES, 11'd2);
    send_beat(CMD_ADD, 32'd8, 32'd3);
    send_beat(CMD_ADD, 32'd4, 32'd4);
    send_beat(CMD_ADD, 32'd9, 32'd5);
    send_beat(CMD_INSERT, 32'd9, 32'd6);
    send_beat(CMD_INSERT, 32'd1, 32'd7);
    write_register(REG_MAX_ENTRIES, 11'd1);
    send_beat(CMD_ADD, 32'd2, 32'd8);
    send_beat(CMD_INSERT, 32'd20, 32'd9);
  endtask

  task automatic test_random_small_caps(int items);
    for (int n = 0; n < items; n++) begin
      if (n % 100 == 0) begin
        write_register(REG_MAX_ENTRIES, 11'($urandom_range(0, 24)));
        write_register(REG_ORDER_REVERSED, 11'($urandom_range(0, 1)));
      end
      send_random_beat(2);
    end
  endtask

  task automatic test_oversize_cap();
    write_register(REG_MAX_ENTRIES, 11'h7FF);
    write_register(REG_ORDER_REVERSED, 11'd1);
    for (int n = 0; n < 80; n++) send_random_beat(1);
  endtask

  task automatic test_full_capacity();
    idle_enable = 1'b0;
    write_register(REG_MAX_ENTRIES, 11'd1024);
    write_register(REG_ORDER_REVERSED, 11'd0);
    send_beat(CMD_CLEAR, 32'd0, 32'd0);
    for (int n = 0; n < 1026; n++) send_beat(CMD_ADD, $urandom, $urandom);
    for (int n = 0; n < 8; n++) send_beat(CMD_INSERT, pick_key(), pick_id());
    for (int n = 0; n < 6; n++) begin
      send_beat(CMD_REMOVE, 32'd0, mdl_ids[$urandom_range(1, mdl_count)]);
      send_beat(CMD_POP, 32'd0, 32'd0);
    end
    write_register(REG_MAX_ENTRIES, 11'd16);
    send_beat(CMD_ADD, 32'd1, 32'd1);
    send_beat(CMD_INSERT, 32'hFFFF_FFFF, 32'd2);
    send_beat(CMD_CLEAR, 32'd0, 32'd0);
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    in_key = '0;
    in_entry_id = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    mdl_count = 0;
    mdl_max_entries = MAX_ENTRIES_RST;
    mdl_reversed = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_small_caps(500);
    test_full_capacity();
    test_oversize_cap();

    drain_results();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== bounded_top_k_heap_queue.f =====
hdl/btkhq_pkg.sv
hdl/bounded_top_k_heap_queue.sv
hdl/btkhq_checker.sv
verif/tb_bounded_top_k_heap_queue.sv
